[rtl/core/rfd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rfd_pkg;

  // Frame framing constants.
  localparam logic [7:0] PfxByte = 8'hAA;
  localparam logic [7:0] OpcA    = 8'h01;
  localparam logic [7:0] OpcB    = 8'h08;

  // Reset value of the receive window length, in ticks.
  localparam logic [15:0] WindowReset = 16'd50;

  // Input item kinds.
  localparam logic ReqByte = 1'b0;
  localparam logic ReqTick = 1'b1;

  // Result kinds.
  localparam logic KindBody = 1'b0;
  localparam logic KindEnd  = 1'b1;

  // Frame end status codes.
  localparam logic [1:0] StatGood     = 2'd0;
  localparam logic [1:0] StatSumErr   = 2'd1;
  localparam logic [1:0] StatTruncate = 2'd2;

  // Parser phases.
  localparam logic [2:0] PhPfx1 = 3'd0;
  localparam logic [2:0] PhPfx2 = 3'd1;
  localparam logic [2:0] PhOpc  = 3'd2;
  localparam logic [2:0] PhLen  = 3'd3;
  localparam logic [2:0] PhBody = 3'd4;
  localparam logic [2:0] PhDev  = 3'd5;
  localparam logic [2:0] PhSum  = 3'd6;
  localparam logic [2:0] PhDrop = 3'd7;

  // One result transaction as it leaves the parser.
  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] data;
    logic [7:0] opcode;
    logic [1:0] status;
  } rfd_result_t;

endpackage

`default_nettype wire

[rtl/core/rfd_parser.sv]
`timescale 1ns / 1ps
`default_nettype none

module rfd_parser (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire  [15:0]          window_ticks_i,
  input  wire                  req_type_i,
  input  wire  [7:0]           rx_byte_i,
  input  wire                  commit_i,
  output rfd_pkg::rfd_result_t res_o
);

  logic [2:0]  phase_q, phase_d;
  logic        win_open_q, win_open_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  left_q, left_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  opc_q, opc_d;

  logic [15:0] cnt_inc;
  logic [2:0]  phase_eff;
  logic [7:0]  sum_add;
  logic [7:0]  left_dec;

  assign cnt_inc  = cnt_q + 16'd1;
  assign sum_add  = sum_q + rx_byte_i;
  assign left_dec = left_q - 8'd1;

  // Next state and result for the item held in the input register.
  always_comb begin
    phase_d    = phase_q;
    win_open_d = win_open_q;
    cnt_d      = cnt_q;
    left_d     = left_q;
    sum_d      = sum_q;
    opc_d      = opc_q;
    phase_eff  = win_open_q ? phase_q : rfd_pkg::PhPfx1;

    res_o        = '0;
    res_o.opcode = opc_q;

    if (req_type_i == rfd_pkg::ReqTick) begin
      // Ticks only count while a window is open.
      if (win_open_q) begin
        if (cnt_inc < window_ticks_i) begin
          cnt_d = cnt_inc;
        end else begin
          win_open_d = 1'b0;
          cnt_d      = '0;
          phase_d    = rfd_pkg::PhPfx1;
          left_d     = '0;
          sum_d      = '0;
          if (phase_q >= rfd_pkg::PhLen && phase_q <= rfd_pkg::PhSum) begin
            res_o.valid  = 1'b1;
            res_o.kind   = rfd_pkg::KindEnd;
            res_o.status = rfd_pkg::StatTruncate;
          end
        end
      end
    end else begin
      // A byte opens the window if needed, then goes through the parser.
      win_open_d = 1'b1;
      if (!win_open_q) begin
        cnt_d = '0;
      end
      unique case (phase_eff)
        rfd_pkg::PhPfx1: begin
          phase_d = (rx_byte_i == rfd_pkg::PfxByte) ? rfd_pkg::PhPfx2 : rfd_pkg::PhDrop;
        end
        rfd_pkg::PhPfx2: begin
          phase_d = (rx_byte_i == rfd_pkg::PfxByte) ? rfd_pkg::PhOpc : rfd_pkg::PhDrop;
        end
        rfd_pkg::PhOpc: begin
          if (rx_byte_i == rfd_pkg::OpcA || rx_byte_i == rfd_pkg::OpcB) begin
            opc_d   = rx_byte_i;
            sum_d   = rx_byte_i;
            phase_d = rfd_pkg::PhLen;
          end else begin
            phase_d = rfd_pkg::PhDrop;
          end
        end
        rfd_pkg::PhLen: begin
          if (rx_byte_i < 8'd2) begin
            phase_d = rfd_pkg::PhDrop;
          end else begin
            sum_d   = sum_add;
            left_d  = rx_byte_i - 8'd2;
            phase_d = (rx_byte_i == 8'd2) ? rfd_pkg::PhDev : rfd_pkg::PhBody;
          end
        end
        rfd_pkg::PhBody: begin
          sum_d  = sum_add;
          left_d = left_dec;
          if (left_dec == 8'd0) begin
            phase_d = rfd_pkg::PhDev;
          end
          res_o.valid = 1'b1;
          res_o.kind  = rfd_pkg::KindBody;
          res_o.data  = rx_byte_i;
        end
        rfd_pkg::PhDev: begin
          sum_d   = sum_add;
          phase_d = rfd_pkg::PhSum;
        end
        rfd_pkg::PhSum: begin
          res_o.valid = 1'b1;
          res_o.kind  = rfd_pkg::KindEnd;
          if (rx_byte_i == sum_q) begin
            phase_d      = rfd_pkg::PhPfx1;
            sum_d        = '0;
            res_o.status = rfd_pkg::StatGood;
          end else begin
            phase_d      = rfd_pkg::PhDrop;
            res_o.status = rfd_pkg::StatSumErr;
          end
        end
        default: begin
          phase_d = phase_eff;
        end
      endcase
    end
  end

  // State registers advance only when the item is committed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= rfd_pkg::PhPfx1;
      win_open_q <= 1'b0;
      cnt_q      <= '0;
      left_q     <= '0;
      sum_q      <= '0;
      opc_q      <= '0;
    end else if (commit_i) begin
      phase_q    <= phase_d;
      win_open_q <= win_open_d;
      cnt_q      <= cnt_d;
      left_q     <= left_d;
      sum_q      <= sum_d;
      opc_q      <= opc_d;
    end
  end

  // A closed window always leaves the parser at the prefix with a clear count.
  a_closed_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !win_open_q |-> (phase_q == rfd_pkg::PhPfx1 && cnt_q == 16'd0 && sum_q == 8'd0))
    else $error("closed window holds stale parser state");

  // Body results come only from the body phase.
  a_body_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.kind == rfd_pkg::KindBody) |-> phase_q == rfd_pkg::PhBody)
    else $error("body result outside body phase");

  // A tick that reports truncation also closes the window.
  a_trunc_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit_i && req_type_i == rfd_pkg::ReqTick && res_o.valid) |=> !win_open_q)
    else $error("truncation did not close the window");

endmodule

`default_nettype wire

[rtl/core/rfd_out_reg.sv]
`timescale 1ns / 1ps
`default_nettype none

module rfd_out_reg (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  load_i,
  input  wire rfd_pkg::rfd_result_t res_i,
  output logic                 busy_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output logic                 out_kind_o,
  output logic [7:0]           out_byte_o,
  output logic [7:0]           out_opcode_o,
  output logic [1:0]           end_status_o
);

  logic       vld_q, vld_d;
  logic       kind_q;
  logic [7:0] byte_q;
  logic [7:0] opc_q;
  logic [1:0] stat_q;

  // The register is busy while it holds a transaction that is not taken.
  assign busy_o = vld_q && out_stall_i;
  assign vld_d  = load_i ? 1'b1 : busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload is captured only on load.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      kind_q <= res_i.kind;
      byte_q <= res_i.data;
      opc_q  <= res_i.opcode;
      stat_q <= res_i.status;
    end
  end

  assign out_valid_o  = vld_q;
  assign out_kind_o   = kind_q;
  assign out_byte_o   = byte_q;
  assign out_opcode_o = opc_q;
  assign end_status_o = stat_q;

endmodule

`default_nettype wire

[rtl/core/rx_frame_deframer_sum_check_core.sv]
// Channel | Direction | Handshake            | Payload
// --------+-----------+----------------------+-------------------------------------------
// in      | input     | in_valid_i/in_stall_o | req_type_i, rx_byte_i
// out     | output    | out_valid_o/out_stall_i | out_kind_o, out_byte_o, out_opcode_o,
//         |           |                      | end_status_o
// cfg     | input     | cfg_we_i             | cfg_wdata_i (window_ticks)
//
// One transaction is accepted per cycle while in_stall_o is low; a result is presented
// on the output in the cycle after the edge that commits its item.
// The rate is set by the combinational parser update between input and result registers.
// An item stalls in the input register only when it produces a result and the
// result register still holds one that is stalled downstream.
// Reset is asynchronous and active low; window_ticks resets to 50.
`timescale 1ns / 1ps
`default_nettype none

module rx_frame_deframer_sum_check_core (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_we_i,
  input  wire [15:0] cfg_wdata_i,
  input  wire        in_valid_i,
  output logic       in_stall_o,
  input  wire        req_type_i,
  input  wire [7:0]  rx_byte_i,
  output logic       out_valid_o,
  input  wire        out_stall_i,
  output logic       out_kind_o,
  output logic [7:0] out_byte_o,
  output logic [7:0] out_opcode_o,
  output logic [1:0] end_status_o
);

  logic [15:0] win_ticks_q;
  logic        in_vld_q, in_vld_d;
  logic        type_q;
  logic [7:0]  byte_q;
  logic        in_accept;
  logic        advance;
  logic        out_busy;
  rfd_pkg::rfd_result_t res;

  // Window length register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_ticks_q <= rfd_pkg::WindowReset;
    end else if (cfg_we_i) begin
      win_ticks_q <= cfg_wdata_i;
    end
  end

  // The held item advances unless its result would overrun a stalled output.
  assign advance    = in_vld_q && !(res.valid && out_busy);
  assign in_stall_o = in_vld_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_vld_d   = in_accept ? 1'b1 : (in_vld_q && !advance);

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      type_q <= req_type_i;
      byte_q <= rx_byte_i;
    end
  end

  rfd_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .window_ticks_i (win_ticks_q),
    .req_type_i     (type_q),
    .rx_byte_i      (byte_q),
    .commit_i       (advance),
    .res_o          (res)
  );

  rfd_out_reg u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (advance && res.valid),
    .res_i        (res),
    .busy_o       (out_busy),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_kind_o   (out_kind_o),
    .out_byte_o   (out_byte_o),
    .out_opcode_o (out_opcode_o),
    .end_status_o (end_status_o)
  );

  // A stall upstream means an item is held that cannot move on.
  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && res.valid && out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // A held item that is stalled is still held in the next cycle.
  a_stall_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> in_vld_q)
    else $error("stalled item was lost");

  // A committed result always lands in the output register.
  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res.valid) |=> out_valid_o)
    else $error("committed result not presented");

endmodule

`default_nettype wire
